@@ rtl/kefr_pkg.sv @@
// Shared types and constants for the keypad event FIFO register block.
package kefr_pkg;

   // operation codes of a request word
   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_WRITE  = 2'd1;
   localparam logic [1:0] OP_INJECT = 2'd2;

   // register map
   localparam int         ADDR_W     = 8;
   localparam int         REG_DEPTH  = 256;
   localparam logic [7:0] ADDR_COUNT = 8'h02;
   localparam logic [7:0] ADDR_INT   = 8'h03;
   localparam logic [7:0] ADDR_EVENT = 8'h04;

   localparam int DATA_W  = 8;
   localparam int CODE_W  = 7;
   localparam int COUNT_W = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RAM_READ,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic exec;     // request word accepted this cycle
      logic capture;  // register file read data is ready
   } ctrl_cmd_type;

   typedef struct packed {
      logic ram_read; // pending request reads the register file RAM
   } ctrl_sts_type;

endpackage

@@ rtl/kefr_req_if.sv @@
// Request channel: register read, register write or key injection word.
interface kefr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] reg_addr;
   logic [7:0] write_data;
   logic [6:0] key_code;
   logic       key_press;

   modport source (output valid, op, reg_addr, write_data, key_code, key_press,
                   input ready);
   modport sink   (input valid, op, reg_addr, write_data, key_code, key_press,
                   output ready);
endinterface

@@ rtl/kefr_rsp_if.sv @@
// Response channel: read data and FIFO status after each request word.
interface kefr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       int_pending;
   logic [3:0] event_count;
   logic       dropped;

   modport source (output valid, read_data, int_pending, event_count, dropped,
                   input ready);
   modport sink   (input valid, read_data, int_pending, event_count, dropped,
                   output ready);
endinterface

@@ rtl/kefr_ram.sv @@
// Generic single-port-write, registered-read RAM.
module kefr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ rtl/kefr_ctrl.sv @@
// Controller state machine: sequences one request word at a time.
module kefr_ctrl import kefr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  ctrl_sts_type sts,
   output ctrl_cmd_type cmd
);
   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = sts.ram_read ? ST_RAM_READ : ST_RESP;
            end
         end
         ST_RAM_READ: state_in = ST_RESP;
         ST_RESP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = (state_ff == ST_IDLE);
      rsp_valid   = (state_ff == ST_RESP);
      cmd.exec    = req_valid && (state_ff == ST_IDLE);
      cmd.capture = (state_ff == ST_RAM_READ);
   end

   a_ram_read_path: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && sts.ram_read |=> cmd.capture)
      else $error("RAM read did not enter capture state");

   a_capture_then_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> rsp_valid)
      else $error("captured read data not presented");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("new word accepted while response pending");
endmodule

@@ rtl/kefr_dpath.sv @@
// Datapath: register file, status bits, key event ring FIFO and response word.
module kefr_dpath import kefr_pkg::*; #(
   parameter int EVENT_DEPTH = 10
) (
   input  logic               clock,
   input  logic               reset,
   input  ctrl_cmd_type       cmd,
   output ctrl_sts_type       sts,
   input  logic [1:0]         op,
   input  logic [ADDR_W-1:0]  reg_addr,
   input  logic [DATA_W-1:0]  write_data,
   input  logic [CODE_W-1:0]  key_code,
   input  logic               key_press,
   output logic [DATA_W-1:0]  read_data,
   output logic               int_pending,
   output logic [COUNT_W-1:0] event_count,
   output logic               dropped
);
   localparam int PtrW = (EVENT_DEPTH > 1) ? $clog2(EVENT_DEPTH) : 1;
   localparam logic [PtrW-1:0]    LastPtr = PtrW'(EVENT_DEPTH - 1);
   localparam logic [COUNT_W-1:0] FullCnt = COUNT_W'(EVENT_DEPTH);

   logic [DATA_W-1:0]    store_ff [EVENT_DEPTH];
   logic [PtrW-1:0]      wp_ff, wp_in, rp_ff, rp_in;
   logic [COUNT_W-1:0]   held_ff, held_in;
   logic                 int_ff, int_in;
   logic [3:0]           hi_ff, hi_in;
   logic [REG_DEPTH-1:0] vld_ff;
   logic                 hit_ff;
   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_int_ff, rsp_drop_ff;
   logic [COUNT_W-1:0]   rsp_cnt_ff;
   logic [DATA_W-1:0]    ram_rd;

   logic is_read, is_write, is_inject, special, has_ev, full;
   logic do_pop, do_push, ram_we;

   always_comb begin
      is_read   = (op == OP_READ);
      is_write  = (op == OP_WRITE);
      is_inject = (op == OP_INJECT);
      special   = (reg_addr == ADDR_COUNT) || (reg_addr == ADDR_INT) ||
                  (reg_addr == ADDR_EVENT);
      has_ev    = (held_ff != '0);
      full      = (held_ff == FullCnt);
      do_pop    = cmd.exec && is_read && (reg_addr == ADDR_EVENT) && has_ev;
      do_push   = cmd.exec && is_inject && !full;
      ram_we    = cmd.exec && is_write && !special;
      sts.ram_read = is_read && !special;
   end

   always_comb begin
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      held_in = held_ff;
      int_in  = int_ff;
      hi_in   = hi_ff;
      if (do_push) begin
         wp_in   = (wp_ff == LastPtr) ? '0 : wp_ff + 1'b1;
         held_in = held_ff + 1'b1;
         int_in  = 1'b1;
      end
      if (do_pop) begin
         rp_in   = (rp_ff == LastPtr) ? '0 : rp_ff + 1'b1;
         held_in = held_ff - 1'b1;
         int_in  = (held_ff != COUNT_W'(1));
      end
      // write-one-to-clear interrupt flag; count nibble is read-only
      if (cmd.exec && is_write && (reg_addr == ADDR_INT) && write_data[0]) begin
         int_in = 1'b0;
      end
      if (cmd.exec && is_write && (reg_addr == ADDR_COUNT)) begin
         hi_in = write_data[7:4];
      end
   end

   always_comb begin
      rsp_data_in = '0;
      if (is_read) begin
         priority if (reg_addr == ADDR_EVENT) begin
            rsp_data_in = has_ev ? store_ff[rp_ff] : '0;
         end else if (reg_addr == ADDR_COUNT) begin
            rsp_data_in = {hi_ff, held_ff};
         end else if (reg_addr == ADDR_INT) begin
            rsp_data_in = {{(DATA_W-1){1'b0}}, int_ff};
         end else begin
            rsp_data_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         rp_ff   <= '0;
         held_ff <= '0;
         int_ff  <= 1'b0;
         hi_ff   <= '0;
         vld_ff  <= '0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         held_ff <= held_in;
         int_ff  <= int_in;
         hi_ff   <= hi_in;
         if (ram_we) begin
            vld_ff[reg_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wp_ff] <= {key_press, key_code};
      end
      if (cmd.exec) begin
         hit_ff      <= vld_ff[reg_addr];
         rsp_data_ff <= rsp_data_in;
         rsp_int_ff  <= int_in;
         rsp_cnt_ff  <= held_in;
         rsp_drop_ff <= is_inject && full;
      end else if (cmd.capture) begin
         // unwritten register file bytes read as zero
         rsp_data_ff <= hit_ff ? ram_rd : '0;
      end
   end

   kefr_ram #(
      .WIDTH (DATA_W),
      .DEPTH (REG_DEPTH)
   ) u_regfile (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (reg_addr),
      .wr_data (write_data),
      .rd_addr (reg_addr),
      .rd_data (ram_rd)
   );

   assign read_data   = rsp_data_ff;
   assign int_pending = rsp_int_ff;
   assign event_count = rsp_cnt_ff;
   assign dropped     = rsp_drop_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= FullCnt)
      else $error("event count exceeds FIFO depth");

   a_empty_no_int: assert property (@(posedge clock) disable iff (reset)
      (held_ff == '0) |-> !int_ff)
      else $error("interrupt flag set with empty FIFO");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      ((held_ff == '0) || (held_ff == FullCnt)) |-> (wp_ff == rp_ff))
      else $error("FIFO pointers disagree with event count");
endmodule

@@ rtl/keypad_event_fifo_registers_top.sv @@
// Top level of the keypad controller register block with key event FIFO.
//
// One request word is handled at a time. A word that touches the status,
// count or event register, a register write or a key injection has its
// response valid in the cycle after acceptance; a read of any other register
// first passes through ST_RAM_READ, the registered read of the 256-byte
// register file RAM. The next word is taken in the cycle after the response
// is accepted. Register file bytes read as zero until first written (per-byte
// valid flags cleared by reset), so no clearing pass follows reset.
module keypad_event_fifo_registers_top import kefr_pkg::*; #(
   parameter int EVENT_DEPTH = 10
) (
   input logic       clock,
   input logic       reset,
   kefr_req_if.sink   req_if,
   kefr_rsp_if.source rsp_if
);
   ctrl_cmd_type cmd;
   ctrl_sts_type sts;

   kefr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kefr_dpath #(
      .EVENT_DEPTH (EVENT_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .op          (req_if.op),
      .reg_addr    (req_if.reg_addr),
      .write_data  (req_if.write_data),
      .key_code    (req_if.key_code),
      .key_press   (req_if.key_press),
      .read_data   (rsp_if.read_data),
      .int_pending (rsp_if.int_pending),
      .event_count (rsp_if.event_count),
      .dropped     (rsp_if.dropped)
   );
endmodule
